### src/or_address_form_validator_core_assert.svh
// Assertion macros for the O/R address form validator.
// Used by the checker module; needs clk and rst in the including scope.
`ifndef OR_ADDRESS_FORM_VALIDATOR_CORE_ASSERT_SVH
`define OR_ADDRESS_FORM_VALIDATOR_CORE_ASSERT_SVH

// clocked check, switched off while reset is held
`define ORAFV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds during reset
`define ORAFV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/orafv_pkg.sv
// Shared types, codes and the per-form limit table of the O/R address validator.
// No dependencies.
package orafv_pkg;

  localparam int unsigned MAX_DOMAIN_DEFINED = 4;
  localparam int unsigned MAX_UNIT_NAMES     = 4;

  // address forms
  localparam logic [2:0] FORM_TERMINAL = 3'd0;
  localparam logic [2:0] FORM_POSTAL   = 3'd1;
  localparam logic [2:0] FORM_NUMERIC  = 3'd2;
  localparam logic [2:0] FORM_MNEMONIC = 3'd3;
  localparam logic [2:0] FORM_UNKNOWN  = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_TOO_MANY    = 3'd1;
  localparam logic [2:0] ERR_NOT_ALLOWED = 3'd2;
  localparam logic [2:0] ERR_MISSING     = 3'd3;
  localparam logic [2:0] ERR_UNFMT_MIX   = 3'd4;
  localparam logic [2:0] ERR_NO_SURNAME  = 3'd5;

  // component type codes
  localparam logic [5:0] T_C        = 6'd0;
  localparam logic [5:0] T_ADMD     = 6'd1;
  localparam logic [5:0] T_X121     = 6'd2;
  localparam logic [5:0] T_PRMD     = 6'd3;
  localparam logic [5:0] T_TID      = 6'd4;
  localparam logic [5:0] T_DD       = 6'd5;
  localparam logic [5:0] T_PDSNAME  = 6'd6;
  localparam logic [5:0] T_PD_C     = 6'd7;
  localparam logic [5:0] T_POSTCODE = 6'd8;
  localparam logic [5:0] T_OR_COMPS = 6'd9;
  localparam logic [5:0] T_UPA_PA   = 6'd19;
  localparam logic [5:0] T_UPN      = 6'd20;
  localparam logic [5:0] T_UAID     = 6'd21;
  localparam logic [5:0] T_CN       = 6'd22;
  localparam logic [5:0] T_O        = 6'd23;
  localparam logic [5:0] T_OU       = 6'd24;
  localparam logic [5:0] T_OU4      = 6'd28;
  localparam logic [5:0] T_S        = 6'd29;
  localparam logic [5:0] T_G        = 6'd30;
  localparam logic [5:0] T_I        = 6'd31;
  localparam logic [5:0] T_GQ       = 6'd32;
  localparam logic [5:0] T_OTHER    = 6'd33;

  // counter slots: codes up to OU map to themselves, OU1..OU4 share OU,
  // S..GQ follow on; "any other type" has no counter
  localparam int unsigned NUM_SLOTS = 29;
  localparam int unsigned SLOT_W    = 5;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [2:0]        cnt_t;

  localparam slot_t SLOT_S  = slot_t'(25);
  localparam slot_t SLOT_G  = slot_t'(26);
  localparam slot_t SLOT_I  = slot_t'(27);
  localparam slot_t SLOT_GQ = slot_t'(28);

  typedef struct packed {
    logic       bad;        // type not allowed in this form
    logic       unlimited;
    logic [2:0] max;
  } limit_t;

  function automatic slot_t slot_of(logic [5:0] t);
    slot_t s;
    if (t <= T_OU) begin
      s = t[SLOT_W-1:0];
    end else if (t <= T_OU4) begin
      s = T_OU[SLOT_W-1:0];
    end else begin
      s = slot_t'(t - 6'd4);
    end
    return s;
  endfunction

  function automatic limit_t limit_of(logic [2:0] form, logic [5:0] t);
    limit_t l;
    l = '{bad: 1'b1, unlimited: 1'b0, max: 3'd0};
    unique case (form)
      FORM_TERMINAL: begin
        if (t == T_C || t == T_ADMD || t == T_X121 || t == T_PRMD || t == T_TID) begin
          l = '{bad: 1'b0, unlimited: 1'b0, max: 3'd1};
        end else if (t == T_DD) begin
          l = '{bad: 1'b0, unlimited: 1'b0, max: 3'(MAX_DOMAIN_DEFINED)};
        end
      end
      FORM_POSTAL: begin
        if (t == T_PRMD || t == T_PDSNAME) begin
          l = '{bad: 1'b0, unlimited: 1'b0, max: 3'd1};
        end else if (t == T_C || t == T_ADMD || (t >= T_PD_C && t <= T_UPN)) begin
          l = '{bad: 1'b0, unlimited: 1'b1, max: 3'd0};
        end
      end
      FORM_NUMERIC: begin
        if (t == T_PRMD) begin
          l = '{bad: 1'b0, unlimited: 1'b0, max: 3'd1};
        end else if (t == T_DD) begin
          l = '{bad: 1'b0, unlimited: 1'b0, max: 3'(MAX_DOMAIN_DEFINED)};
        end else if (t == T_C || t == T_ADMD || t == T_UAID) begin
          l = '{bad: 1'b0, unlimited: 1'b1, max: 3'd0};
        end
      end
      FORM_MNEMONIC: begin
        if (t == T_CN || t == T_PRMD || t == T_O) begin
          l = '{bad: 1'b0, unlimited: 1'b0, max: 3'd1};
        end else if (t >= T_OU && t <= T_OU4) begin
          l = '{bad: 1'b0, unlimited: 1'b0, max: 3'(MAX_UNIT_NAMES)};
        end else if (t == T_DD) begin
          l = '{bad: 1'b0, unlimited: 1'b0, max: 3'(MAX_DOMAIN_DEFINED)};
        end else if (t == T_C || t == T_ADMD || (t >= T_S && t <= T_GQ)) begin
          l = '{bad: 1'b0, unlimited: 1'b1, max: 3'd0};
        end
      end
      default: begin
        l = '{bad: 1'b0, unlimited: 1'b1, max: 3'd0};
      end
    endcase
    return l;
  endfunction

endpackage

### src/or_address_form_validator_core.sv
// O/R address form validator: one component word in, one verdict word per address.
// Depends on orafv_pkg.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_stall  | address_form, component_type, last_component
//  out     | out_valid/out_stall| address_valid, error_code, error_component
//
// One word per cycle sustained; an input register feeds the counter update and
// final checks, which load the result register, so the verdict word is offered
// once the last word has left the input register. Other words produce no result.
// Synchronous reset clears the counters, error and address-start state.
// A stalled result holds; the input register keeps taking words until it is
// full behind a stalled result, then in_stall rises.
module or_address_form_validator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] address_form,
  input  logic [5:0] component_type,
  input  logic       last_component,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       address_valid,
  output logic [2:0] error_code,
  output logic [5:0] error_component
);

  // input register
  logic       s1_valid;
  logic [2:0] s1_form;
  logic [5:0] s1_type;
  logic       s1_last;

  // address state
  logic                 at_start;
  logic [2:0]           held_form;
  orafv_pkg::cnt_t      cnt [orafv_pkg::NUM_SLOTS];
  logic [2:0]           first_error;
  logic [5:0]           first_error_type;

  // working values
  logic                 s1_adv;
  logic                 step;
  logic [5:0]           t_c;
  logic [2:0]           form_eff;
  orafv_pkg::limit_t    lim;
  logic                 has_cnt;
  orafv_pkg::slot_t     idx;
  orafv_pkg::cnt_t      cur;
  orafv_pkg::cnt_t      cnt_upd [orafv_pkg::NUM_SLOTS];
  logic [2:0]           err_a;
  logic [5:0]           etype_a;
  logic [2:0]           err_f;
  logic [5:0]           etype_f;
  logic                 mix;
  logic                 no_surname;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_valid && !s1_adv;
  assign step     = s1_valid && s1_adv;

  always_comb begin
    t_c = (s1_type > orafv_pkg::T_OTHER) ? orafv_pkg::T_OTHER : s1_type;
    if (at_start) begin
      form_eff = (s1_form > orafv_pkg::FORM_UNKNOWN) ? orafv_pkg::FORM_UNKNOWN : s1_form;
    end else begin
      form_eff = held_form;
    end
    lim     = orafv_pkg::limit_of(form_eff, t_c);
    has_cnt = (t_c != orafv_pkg::T_OTHER);
    idx     = has_cnt ? orafv_pkg::slot_of(t_c) : '0;
    cur     = cnt[idx];

    err_a   = first_error;
    etype_a = first_error_type;
    cnt_upd = cnt;
    // once an error is held, later words leave the counters alone
    if (first_error == orafv_pkg::ERR_NONE) begin
      if (lim.bad) begin
        err_a   = orafv_pkg::ERR_NOT_ALLOWED;
        etype_a = t_c;
      end else if (!lim.unlimited && cur >= lim.max) begin
        err_a   = orafv_pkg::ERR_TOO_MANY;
        etype_a = t_c;
      end else if (has_cnt && cur != 3'd7) begin
        cnt_upd[idx] = cur + 3'd1;
      end
    end

    // detailed postal components alongside the unformatted address
    mix = 1'b0;
    for (int k = int'(orafv_pkg::T_OR_COMPS); k <= int'(orafv_pkg::T_UPN); k++) begin
      if (k != int'(orafv_pkg::T_UPA_PA)) begin
        mix = mix | (cnt_upd[orafv_pkg::slot_t'(k)] != 3'd0);
      end
    end
    no_surname = (cnt_upd[orafv_pkg::SLOT_S] == 3'd0) &&
                 ((cnt_upd[orafv_pkg::SLOT_G] != 3'd0) ||
                  (cnt_upd[orafv_pkg::SLOT_I] != 3'd0) ||
                  (cnt_upd[orafv_pkg::SLOT_GQ] != 3'd0));

    err_f   = err_a;
    etype_f = etype_a;
    if (err_a == orafv_pkg::ERR_NONE) begin
      unique case (form_eff)
        orafv_pkg::FORM_TERMINAL: begin
          if (cnt_upd[orafv_pkg::T_X121[4:0]] == 3'd0) begin
            err_f = orafv_pkg::ERR_MISSING; etype_f = orafv_pkg::T_X121;
          end
        end
        orafv_pkg::FORM_POSTAL: begin
          priority if (cnt_upd[orafv_pkg::T_C[4:0]] == 3'd0) begin
            err_f = orafv_pkg::ERR_MISSING; etype_f = orafv_pkg::T_C;
          end else if (cnt_upd[orafv_pkg::T_ADMD[4:0]] == 3'd0) begin
            err_f = orafv_pkg::ERR_MISSING; etype_f = orafv_pkg::T_ADMD;
          end else if (cnt_upd[orafv_pkg::T_PD_C[4:0]] == 3'd0) begin
            err_f = orafv_pkg::ERR_MISSING; etype_f = orafv_pkg::T_PD_C;
          end else if (cnt_upd[orafv_pkg::T_POSTCODE[4:0]] == 3'd0) begin
            err_f = orafv_pkg::ERR_MISSING; etype_f = orafv_pkg::T_POSTCODE;
          end else if (cnt_upd[orafv_pkg::T_UPA_PA[4:0]] == 3'd1 && mix) begin
            err_f = orafv_pkg::ERR_UNFMT_MIX; etype_f = orafv_pkg::T_UPA_PA;
          end
        end
        orafv_pkg::FORM_NUMERIC: begin
          priority if (cnt_upd[orafv_pkg::T_C[4:0]] == 3'd0) begin
            err_f = orafv_pkg::ERR_MISSING; etype_f = orafv_pkg::T_C;
          end else if (cnt_upd[orafv_pkg::T_ADMD[4:0]] == 3'd0) begin
            err_f = orafv_pkg::ERR_MISSING; etype_f = orafv_pkg::T_ADMD;
          end else if (cnt_upd[orafv_pkg::T_UAID[4:0]] == 3'd0) begin
            err_f = orafv_pkg::ERR_MISSING; etype_f = orafv_pkg::T_UAID;
          end
        end
        orafv_pkg::FORM_MNEMONIC: begin
          priority if (cnt_upd[orafv_pkg::T_C[4:0]] == 3'd0) begin
            err_f = orafv_pkg::ERR_MISSING; etype_f = orafv_pkg::T_C;
          end else if (cnt_upd[orafv_pkg::T_ADMD[4:0]] == 3'd0) begin
            err_f = orafv_pkg::ERR_MISSING; etype_f = orafv_pkg::T_ADMD;
          end else if (no_surname) begin
            err_f = orafv_pkg::ERR_NO_SURNAME; etype_f = orafv_pkg::T_S;
          end
        end
        default: begin
          if (no_surname) begin
            err_f = orafv_pkg::ERR_NO_SURNAME; etype_f = orafv_pkg::T_S;
          end
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_form <= address_form;
      s1_type <= component_type;
      s1_last <= last_component;
    end
  end

  // address state; rearmed after the last word
  always_ff @(posedge clk) begin
    if (rst || (step && s1_last)) begin
      at_start         <= 1'b1;
      held_form        <= orafv_pkg::FORM_TERMINAL;
      first_error      <= orafv_pkg::ERR_NONE;
      first_error_type <= '0;
      for (int i = 0; i < orafv_pkg::NUM_SLOTS; i++) begin
        cnt[i] <= '0;
      end
    end else if (step) begin
      at_start         <= 1'b0;
      held_form        <= form_eff;
      first_error      <= err_a;
      first_error_type <= etype_a;
      cnt              <= cnt_upd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_last) begin
      address_valid   <= (err_f == orafv_pkg::ERR_NONE);
      error_code      <= err_f;
      error_component <= etype_f;
    end
  end

endmodule

### src/orafv_checker.sv
// Port-level checks for or_address_form_validator_core, attached by bind.
// Depends on orafv_pkg and or_address_form_validator_core_assert.svh.
`include "or_address_form_validator_core_assert.svh"

module orafv_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] address_form,
  input logic [5:0] component_type,
  input logic       last_component,
  input logic       out_valid,
  input logic       out_stall,
  input logic       address_valid,
  input logic [2:0] error_code,
  input logic [5:0] error_component
);

  `ORAFV_ASSERT(a_out_hold,
    out_valid && out_stall |=> out_valid && $stable(error_code) &&
      $stable(error_component) && $stable(address_valid),
    "stalled result word changed")
  `ORAFV_ASSERT(a_valid_code,
    out_valid |-> (address_valid == (error_code == orafv_pkg::ERR_NONE)),
    "verdict disagrees with error code")
  `ORAFV_ASSERT(a_ok_comp,
    out_valid && address_valid |-> error_component == 6'd0,
    "valid address with a component set")
  `ORAFV_ASSERT(a_fixed_comp,
    out_valid && (error_code == orafv_pkg::ERR_UNFMT_MIX ||
      error_code == orafv_pkg::ERR_NO_SURNAME) |->
      (error_component == orafv_pkg::T_UPA_PA || error_component == orafv_pkg::T_S),
    "wrong component for mix or surname error")
  `ORAFV_ASSERT_ALWAYS(a_no_stall_idle, !out_valid |-> !in_stall,
    "input stalled with no result pending")

endmodule

bind or_address_form_validator_core orafv_checker u_orafv_checker (.*);
